FILE: sv/gcwm_pkg.sv
// ----------------------------------------------------------------------------
// gcwm_pkg: shared types and constants of the ghost cell wall mirror
// Widths of the geometry words, the divider shape and the queue entry.
// ----------------------------------------------------------------------------
package gcwm_pkg;

  // Width of every Q16.16 field on the ports.
  localparam int W = 32;
  // Scaled wall normal component: magnitude below 2^30.
  localparam int DW = 31;
  // Raw normal component and location sum.
  localparam int SW = 33;
  // Doubled centroid offset from the pair midpoint.
  localparam int AW = 34;
  // Products of two normal components, and the divisor.
  localparam int DVW = 62;
  // Signed numerator and its magnitude.
  localparam int NW = 98;
  localparam int MW = NW - 1;
  // Quotient bits produced by the divider; larger quotients always clip.
  localparam int QB = 35;
  // Partial remainder width.
  localparam int RW = DVW;
  // Low half of a split multiplier operand.
  localparam int SPLIT = 31;
  // Default depth of the queue between front and back.
  localparam int FIFO_DEPTH = 4;
  // Port payload widths.
  localparam int IN_BITS = 10 * W;
  localparam int OUT_BITS = 4 * W;

  // One classified pair, as it waits in the queue.
  typedef struct packed {
    logic [W-1:0]  vx;
    logic [W-1:0]  vy;
    logic [W-1:0]  wx;
    logic [W-1:0]  wy;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
    logic          degen;
  } gcwm_item_t;

  // Fields that ride alongside the arithmetic in the back part.
  typedef struct packed {
    logic [W-1:0] wx;
    logic [W-1:0] wy;
    logic         degen;
    logic [3:0]   neg;
  } gcwm_side_t;

endpackage

FILE: sv/gcwm_front.sv
// ----------------------------------------------------------------------------
// gcwm_front: pair classifier
// Forms the wall normal, flags coinciding particles, scales long normals
// down, and builds the location sum and centroid offset for the queue.
// ----------------------------------------------------------------------------
module gcwm_front import gcwm_pkg::*; (
  input  logic [IN_BITS-1:0] tdata,
  output gcwm_item_t         item
);

  localparam logic signed [SW-1:0] LIM30 = SW'(64'sd1073741824);
  localparam logic signed [SW-1:0] LIM31 = SW'(64'sd2147483648);

  logic signed [W-1:0]  ix, iy, ox, oy, cx, cy;
  logic signed [SW-1:0] dx_full, dy_full, sx, sy;
  logic [1:0]           lvx, lvy, sh;

  // Magnitude class of one raw normal component.
  function automatic logic [1:0] mag_level(input logic signed [SW-1:0] x);
    logic [1:0] lv;
    lv = 2'd0;
    if (x >= LIM30 || x <= -LIM30) begin
      lv = 2'd1;
    end
    if (x >= LIM31 || x <= -LIM31) begin
      lv = 2'd2;
    end
    return lv;
  endfunction

  // Divide by 2^sh, truncating toward zero.
  function automatic logic [DW-1:0] scale(input logic signed [SW-1:0] x,
                                          input logic [1:0] sh_in);
    logic signed [SW-1:0] bias;
    logic signed [SW-1:0] t;
    bias = x[SW-1] ? $signed((SW'(1) << sh_in) - SW'(1)) : '0;
    t = (x + bias) >>> sh_in;
    return DW'(t);
  endfunction

  // Unpack the word.
  assign ix = tdata[0*W +: W];
  assign iy = tdata[1*W +: W];
  assign ox = tdata[2*W +: W];
  assign oy = tdata[3*W +: W];
  assign cx = tdata[8*W +: W];
  assign cy = tdata[9*W +: W];

  // Wall normal and midpoint terms.
  assign dx_full = SW'(ox) - SW'(ix);
  assign dy_full = SW'(oy) - SW'(iy);
  assign sx = SW'(ix) + SW'(ox);
  assign sy = SW'(iy) + SW'(oy);

  // Halvings needed to bring both components below 2^30.
  assign lvx = mag_level(dx_full);
  assign lvy = mag_level(dy_full);
  assign sh = (lvx > lvy) ? lvx : lvy;

  // Queue entry.
  always_comb begin
    item.vx = tdata[4*W +: W];
    item.vy = tdata[5*W +: W];
    item.wx = tdata[6*W +: W];
    item.wy = tdata[7*W +: W];
    item.dx = scale(dx_full, sh);
    item.dy = scale(dy_full, sh);
    item.sx = sx;
    item.sy = sy;
    item.ax = AW'(cx) + AW'(cx) - AW'(sx);
    item.ay = AW'(cy) + AW'(cy) - AW'(sy);
    item.degen = (dx_full == '0) && (dy_full == '0);
  end

endmodule

FILE: sv/gcwm_fifo.sv
// ----------------------------------------------------------------------------
// gcwm_fifo: queue between classifier and arithmetic
// A small register queue so that the two sides stall independently.
// ----------------------------------------------------------------------------
module gcwm_fifo import gcwm_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  gcwm_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output gcwm_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gcwm_item_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          push, pop;

  // Handshakes.
  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_ready && pop_valid;
  assign pop_item = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count missed a write");

endmodule

FILE: sv/gcwm_div.sv
// ----------------------------------------------------------------------------
// gcwm_div: pipelined restoring divider
// One quotient bit per stage; flags quotients of 2^QB or more as overflow.
// ----------------------------------------------------------------------------
module gcwm_div import gcwm_pkg::*; (
  input  logic           clk,
  input  logic           ce,
  input  logic [MW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic [QB-1:0]  quo,
  output logic [RW-1:0]  rem,
  output logic [DVW-1:0] den_out,
  output logic           ovf
);

  logic [RW-1:0]  rem_r [QB+1];
  logic [QB-1:0]  low_r [QB+1];
  logic [QB-1:0]  quo_r [QB+1];
  logic [DVW-1:0] den_r [QB+1];
  logic           ovf_r [QB+1];
  logic [RW:0]    trial [QB];
  logic           ge    [QB];

  // Trial subtraction of each stage.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_r[k], low_r[k][QB-1-k]};
      ge[k] = (trial[k] >= {1'b0, den_r[k]});
    end
  end

  // Entry stage takes the high part of the numerator as first remainder.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= num[MW-1:QB];
      ovf_r[0] <= (num[MW-1:QB] >= den);
      low_r[0] <= num[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      for (int k = 0; k < QB; k++) begin
        rem_r[k+1] <= ge[k] ? RW'(trial[k] - {1'b0, den_r[k]}) : trial[k][RW-1:0];
        low_r[k+1] <= low_r[k];
        quo_r[k+1] <= quo_r[k] | (QB'(ge[k]) << (QB - 1 - k));
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = quo_r[QB];
  assign rem = rem_r[QB];
  assign den_out = den_r[QB];
  assign ovf = ovf_r[QB];

endmodule

FILE: sv/gcwm_back.sv
// ----------------------------------------------------------------------------
// gcwm_back: mirror arithmetic pipeline
// Squares the normal, forms the mirrored numerators with split multipliers,
// divides, rounds, adds twice the wall velocity and saturates.
// ----------------------------------------------------------------------------
module gcwm_back import gcwm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  output logic                head_pop,
  input  gcwm_item_t          head,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] ghost_vel_x,
  output logic signed [W-1:0] ghost_vel_y,
  output logic signed [W-1:0] ghost_centroid_x,
  output logic signed [W-1:0] ghost_centroid_y,
  output logic                degenerate,
  output logic                saturated
);

  // Product slots.
  localparam int P_VXC = 0;
  localparam int P_VYE = 1;
  localparam int P_VYC = 2;
  localparam int P_VXE = 3;
  localparam int P_AXC = 4;
  localparam int P_AYE = 5;
  localparam int P_AYC = 6;
  localparam int P_AXE = 7;
  localparam int P_SXD = 8;
  localparam int P_SYD = 9;
  localparam int NPROD = 10;
  localparam int XW = QB + 3;
  localparam logic signed [XW-1:0] SMAX = XW'(32'sh7FFFFFFF);
  localparam logic signed [XW-1:0] SMIN = ~SMAX;

  logic ce;

  // Stage registers.
  logic                  v1, v2, v3, v4, v5, v6;
  gcwm_item_t            it1, it2;
  logic signed [DVW-1:0] dx2_1, dy2_1, dxy_1;
  logic signed [DVW-1:0] c2, e2, dd2;
  gcwm_side_t            side3, side4, side5, side6;
  logic signed [DVW-1:0] dd3, dd4, dd5;
  logic signed [AW-1:0]  opa [NPROD];
  logic signed [DVW-1:0] opb [NPROD];
  logic signed [AW+SPLIT:0]   plo3 [NPROD];
  logic signed [AW+SPLIT-1:0] phi3 [NPROD];
  logic signed [NW-1:0]  full4 [NPROD];
  logic signed [NW-1:0]  num5 [4];
  logic [MW-1:0]         mag6 [4];
  logic [DVW-1:0]        den6 [4];
  logic [QB:0]           vline;
  gcwm_side_t            sline [QB+1];

  // Divider outputs and final values.
  logic [QB-1:0]         dq   [4];
  logic [RW-1:0]         drem [4];
  logic [DVW-1:0]        dden [4];
  logic                  dovf [4];
  logic [W:0]            fin  [4];
  logic signed [W:0]     bias [4];

  // Round, add the wall term and clip; returns {clip, value}.
  function automatic logic [W:0] finish(input logic [QB-1:0] q,
                                        input logic [RW-1:0] r,
                                        input logic [DVW-1:0] d,
                                        input logic o,
                                        input logic n,
                                        input logic signed [W:0] b);
    logic [QB:0]           qr;
    logic signed [QB+1:0]  sv;
    logic signed [XW-1:0]  sum;
    logic                  clip;
    logic [W-1:0]          res;
    qr = {1'b0, q} + (QB+1)'({r, 1'b0} >= {1'b0, d});
    sv = n ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    sum = XW'(sv) + XW'(b);
    clip = 1'b0;
    res = sum[W-1:0];
    if (o) begin
      clip = 1'b1;
      res = n ? W'(SMIN) : W'(SMAX);
    end else if (sum > SMAX) begin
      clip = 1'b1;
      res = W'(SMAX);
    end else if (sum < SMIN) begin
      clip = 1'b1;
      res = W'(SMIN);
    end
    return {clip, res};
  endfunction

  // The whole pipeline moves when the output register can take a word.
  assign ce = !out_valid || out_ready;
  assign head_pop = ce;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      vline <= '0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      vline <= {vline[QB-1:0], v6};
      out_valid <= vline[QB];
    end
  end

  // Stages 1 and 2: squares of the normal, then the mirror coefficients.
  always_ff @(posedge clk) begin
    if (ce) begin
      it1 <= head;
      dx2_1 <= $signed(head.dx) * $signed(head.dx);
      dy2_1 <= $signed(head.dy) * $signed(head.dy);
      dxy_1 <= $signed(head.dx) * $signed(head.dy);
      it2 <= it1;
      c2 <= dy2_1 - dx2_1;
      e2 <= dxy_1 <<< 1;
      dd2 <= dx2_1 + dy2_1;
    end
  end

  // Operand pairs for the split multipliers.
  always_comb begin
    opa[P_VXC] = AW'($signed(it2.vx));
    opb[P_VXC] = c2;
    opa[P_VYE] = AW'($signed(it2.vy));
    opb[P_VYE] = e2;
    opa[P_VYC] = AW'($signed(it2.vy));
    opb[P_VYC] = c2;
    opa[P_VXE] = AW'($signed(it2.vx));
    opb[P_VXE] = e2;
    opa[P_AXC] = $signed(it2.ax);
    opb[P_AXC] = c2;
    opa[P_AYE] = $signed(it2.ay);
    opb[P_AYE] = e2;
    opa[P_AYC] = $signed(it2.ay);
    opb[P_AYC] = c2;
    opa[P_AXE] = $signed(it2.ax);
    opb[P_AXE] = e2;
    opa[P_SXD] = AW'($signed(it2.sx));
    opb[P_SXD] = dd2;
    opa[P_SYD] = AW'($signed(it2.sy));
    opb[P_SYD] = dd2;
  end

  // Stages 3 and 4: half products, then whole products.
  always_ff @(posedge clk) begin
    if (ce) begin
      side3.wx <= it2.wx;
      side3.wy <= it2.wy;
      side3.degen <= it2.degen;
      side3.neg <= '0;
      dd3 <= dd2;
      for (int k = 0; k < NPROD; k++) begin
        plo3[k] <= opa[k] * $signed({1'b0, opb[k][SPLIT-1:0]});
        phi3[k] <= opa[k] * $signed(opb[k][DVW-1:SPLIT]);
      end
      side4 <= side3;
      dd4 <= dd3;
      for (int k = 0; k < NPROD; k++) begin
        full4[k] <= (NW'(phi3[k]) <<< SPLIT) + NW'(plo3[k]);
      end
    end
  end

  // Stages 5 and 6: mirrored numerators, then magnitude, sign and divisor.
  always_ff @(posedge clk) begin
    if (ce) begin
      side5 <= side4;
      dd5 <= dd4;
      num5[0] <= full4[P_VXC] - full4[P_VYE];
      num5[1] <= -(full4[P_VYC] + full4[P_VXE]);
      num5[2] <= full4[P_AXC] - full4[P_AYE] + full4[P_SXD];
      num5[3] <= full4[P_SYD] - full4[P_AYC] - full4[P_AXE];
      side6.wx <= side5.wx;
      side6.wy <= side5.wy;
      side6.degen <= side5.degen;
      for (int k = 0; k < 4; k++) begin
        side6.neg[k] <= num5[k][NW-1];
        mag6[k] <= num5[k][NW-1] ? MW'(-num5[k]) : MW'(num5[k]);
      end
      den6[0] <= DVW'(dd5);
      den6[1] <= DVW'(dd5);
      den6[2] <= DVW'(dd5) << 1;
      den6[3] <= DVW'(dd5) << 1;
    end
  end

  // Four dividers in step.
  for (genvar g = 0; g < 4; g++) begin : g_div
    gcwm_div u_div (
      .clk     (clk),
      .ce      (ce),
      .num     (mag6[g]),
      .den     (den6[g]),
      .quo     (dq[g]),
      .rem     (drem[g]),
      .den_out (dden[g]),
      .ovf     (dovf[g])
    );
  end

  // Side fields follow the dividers.
  always_ff @(posedge clk) begin
    if (ce) begin
      sline[0] <= side6;
      for (int k = 1; k <= QB; k++) begin
        sline[k] <= sline[k-1];
      end
    end
  end

  // Final rounding and clipping.
  always_comb begin
    bias[0] = $signed({sline[QB].wx, 1'b0});
    bias[1] = $signed({sline[QB].wy, 1'b0});
    bias[2] = '0;
    bias[3] = '0;
    for (int k = 0; k < 4; k++) begin
      fin[k] = finish(dq[k], drem[k], dden[k], dovf[k], sline[QB].neg[k], bias[k]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ce) begin
      if (sline[QB].degen) begin
        ghost_vel_x <= '0;
        ghost_vel_y <= '0;
        ghost_centroid_x <= '0;
        ghost_centroid_y <= '0;
        degenerate <= 1'b1;
        saturated <= 1'b0;
      end else begin
        ghost_vel_x <= fin[0][W-1:0];
        ghost_vel_y <= fin[1][W-1:0];
        ghost_centroid_x <= fin[2][W-1:0];
        ghost_centroid_y <= fin[3][W-1:0];
        degenerate <= 1'b0;
        saturated <= fin[0][W] | fin[1][W] | fin[2][W] | fin[3][W];
      end
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> ghost_vel_x == '0 && ghost_vel_y == '0 &&
      ghost_centroid_x == '0 && ghost_centroid_y == '0 && !saturated)
    else $error("degenerate word carries nonzero values");

endmodule

FILE: sv/ghost_cell_wall_mirror.sv
// ----------------------------------------------------------------------------
// ghost_cell_wall_mirror: reflective wall ghost cell for one particle pair
// Mirrors the outer cell velocity across the wall tangent, adds twice the
// wall velocity, and reflects the outer centroid about the pair midpoint.
// Throughput: one word per cycle, sustained while m_axis_tready keeps the output moving, on both sides.
// The delay from input acceptance to output valid is set by the queue, the product stages and the
// 35-stage quotient pipeline of the four dividers.
// The input side stays ready while the queue (four entries by default) has room.
// Reset (rst, synchronous) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
module ghost_cell_wall_mirror import gcwm_pkg::*; #(
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // inner_x, inner_y, outer_x, outer_y, fluid_vel_x, fluid_vel_y,
  // wall_vel_x, wall_vel_y, centroid_x, centroid_y
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ghost_vel_x, ghost_vel_y, ghost_centroid_x, ghost_centroid_y
  output logic [OUT_BITS-1:0] m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]          m_axis_tuser
);

  gcwm_item_t          item_in, item_head;
  logic                head_valid, head_pop;
  logic signed [W-1:0] gvx, gvy, gcx, gcy;
  logic                degen, sat;

  // Classifier.
  gcwm_front u_front (
    .tdata (s_axis_tdata),
    .item  (item_in)
  );

  // Queue between classifier and arithmetic.
  gcwm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_axis_tvalid),
    .push_ready (s_axis_tready),
    .push_item  (item_in),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_item   (item_head)
  );

  // Arithmetic pipeline.
  gcwm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_pop         (head_pop),
    .head             (item_head),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .ghost_vel_x      (gvx),
    .ghost_vel_y      (gvy),
    .ghost_centroid_x (gcx),
    .ghost_centroid_y (gcy),
    .degenerate       (degen),
    .saturated        (sat)
  );

  // Output packing.
  assign m_axis_tdata = {gcy, gcx, gvy, gvx};
  assign m_axis_tuser = {sat, degen};

endmodule
